// File: src/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, constants and codes for the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  // field widths
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'd1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

  // grey space on black, the cell value after reset
  localparam logic [CELL_W-1:0] CELL_RESET = {BG_RESET, FG_RESET, CH_SPACE};

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  read_index;
  } in_t;

  // result word
  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // input word taken this cycle
    logic sweep_init;   // reset fill of the store
    logic sweep_clear;  // clear fill in current colours
    logic scroll;       // line move pass
    logic load;         // load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_clear;
    logic need_scroll;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: src/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencing state machine for the text console writer
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::dp_stat_t  ctrl_stat,
  output tcw_pkg::dp_cmd_t   ctrl_cmd
);
  import tcw_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_CLEAR  = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl_cmd  = '0;
    unique case (state_r)
      ST_INIT: begin
        ctrl_cmd.sweep_init = 1'b1;
        if (ctrl_stat.scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          ctrl_cmd.accept = 1'b1;
          if (ctrl_stat.need_clear) begin
            state_nxt = ST_CLEAR;
          end else if (ctrl_stat.need_scroll) begin
            state_nxt = ST_SCROLL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        ctrl_cmd.sweep_clear = 1'b1;
        if (ctrl_stat.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL: begin
        ctrl_cmd.scroll = 1'b1;
        if (ctrl_stat.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctrl_stat.out_free) begin
          ctrl_cmd.load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/tcw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_dp
// cursor, screen store, scan counter and result register
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::in_t                  in_data,
  input  logic [tcw_pkg::COLOR_W-1:0]   fg_color,
  input  logic [tcw_pkg::COLOR_W-1:0]   bg_color,
  input  tcw_pkg::dp_cmd_t              ctrl_cmd,
  output tcw_pkg::dp_stat_t             ctrl_stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output tcw_pkg::out_t                 out_data
);
  import tcw_pkg::*;

  localparam int CELL_CNT  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W    = $clog2(CELL_CNT);
  localparam int ROW_W     = $clog2(SCREEN_ROWS);
  localparam int COL_W     = $clog2(SCREEN_COLUMNS);
  localparam int POS_EXT_W = (ADDR_W > POS_W) ? ADDR_W : POS_W;
  localparam int CMP_W     = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;

  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_CNT - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELL_CNT - SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] LINE_STEP  = ADDR_W'(SCREEN_COLUMNS);

  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ADDR_W-1:0]    scan_r;
  logic [ADDR_W-1:0]    cur_pos;
  logic [POS_EXT_W-1:0] pos_ext;
  logic [CMP_W-1:0]     idx_ext;
  logic                 idx_ok;
  logic [CELL_W-1:0]    blank_cell;

  logic is_put, is_read, is_nl, is_cr, is_bs, is_chr;
  logic at_last_row, at_last_col;

  logic                 put_wr;
  logic [ADDR_W-1:0]    put_addr;
  logic [CELL_W-1:0]    put_data;

  logic [CELL_W-1:0]    cells_mem [CELL_CNT];
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [CELL_W-1:0]    wr_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [CELL_W-1:0]    rd_data_r;
  logic                 rd_hit_r;

  logic                 blank_row;
  logic                 pend_r;
  logic                 pend_blank_r;
  logic [ADDR_W-1:0]    pend_addr_r;

  logic                 out_valid_r;
  out_t                 out_data_r;

  // decode
  assign is_put  = (in_data.cmd == CMD_PUT);
  assign is_read = (in_data.cmd == CMD_READ);
  assign is_nl   = is_put && (in_data.char_code == CH_NEWLINE);
  assign is_cr   = is_put && (in_data.char_code == CH_RETURN);
  assign is_bs   = is_put && (in_data.char_code == CH_BACKSPACE);
  assign is_chr  = is_put && !is_nl && !is_cr && !is_bs;

  assign at_last_row = (row_r == LAST_ROW);
  assign at_last_col = (col_r == LAST_COL);

  assign cur_pos = ADDR_W'(row_r) * LINE_STEP + ADDR_W'(col_r);
  assign pos_ext = POS_EXT_W'(cur_pos);

  assign idx_ext = CMP_W'(in_data.read_index);
  assign idx_ok  = (idx_ext < CMP_W'(CELL_CNT));

  assign blank_cell = {bg_color, fg_color, CH_SPACE};

  // cursor movement and the single cell write of a put
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    put_wr   = 1'b0;
    put_addr = cur_pos;
    put_data = blank_cell;
    if (in_data.cmd == CMD_CLEAR) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (is_nl) begin
      col_nxt = '0;
      if (!at_last_row) begin
        row_nxt = row_r + ROW_W'(1);
      end
    end else if (is_cr) begin
      col_nxt = '0;
    end else if (is_bs) begin
      if (col_r != '0) begin
        col_nxt  = col_r - COL_W'(1);
        put_wr   = 1'b1;
        put_addr = cur_pos - ADDR_W'(1);
      end
    end else if (is_chr) begin
      put_wr   = 1'b1;
      put_data = {bg_color, fg_color, in_data.char_code};
      if (at_last_col) begin
        col_nxt = '0;
        if (!at_last_row) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (ctrl_cmd.accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // scan counter, wraps after the last cell so every pass starts at zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (ctrl_cmd.sweep_init || ctrl_cmd.sweep_clear || ctrl_cmd.scroll) begin
      scan_r <= (scan_r == LAST_CELL) ? '0 : scan_r + ADDR_W'(1);
    end
  end

  // scroll: read one line below, write here in the next cycle
  assign blank_row = (scan_r >= BOTTOM_ROW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= ctrl_cmd.scroll;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r  <= scan_r;
    pend_blank_r <= blank_row;
  end

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan_r;
    wr_data = CELL_RESET;
    if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = pend_blank_r ? blank_cell : rd_data_r;
    end else if (ctrl_cmd.sweep_init) begin
      wr_en = 1'b1;
    end else if (ctrl_cmd.sweep_clear) begin
      wr_en   = 1'b1;
      wr_data = blank_cell;
    end else if (ctrl_cmd.accept && put_wr) begin
      wr_en   = 1'b1;
      wr_addr = put_addr;
      wr_data = put_data;
    end
  end

  // store read port
  assign rd_en   = (ctrl_cmd.scroll && !blank_row) || (ctrl_cmd.accept && is_read && idx_ok);
  assign rd_addr = ctrl_cmd.scroll ? scan_r + LINE_STEP : idx_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cells_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hit_r <= 1'b0;
    end else if (ctrl_cmd.accept) begin
      rd_hit_r <= is_read && idx_ok;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      out_data_r.cursor_pos <= pos_ext[POS_W-1:0];
      out_data_r.cell_data  <= rd_hit_r ? rd_data_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ctrl_stat.need_clear  = (in_data.cmd == CMD_CLEAR);
  assign ctrl_stat.need_scroll = at_last_row && (is_nl || (is_chr && at_last_col));
  assign ctrl_stat.scan_last   = (scan_r == LAST_CELL);
  assign ctrl_stat.out_free    = !out_valid_r || !out_stall;

endmodule

// File: src/text_console_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// text-mode console writer with an on-chip screen store of 16-bit cells
// ----------------------------------------------------------------------------
// After reset the block fills its screen store with grey-on-black spaces, one
// cell per cycle, over every cell of the store; in_stall stays high during
// that fill and colour writes are still taken.
// A put of an ordinary character, return, backspace, a read or an unused
// command does the cell write or the store read in the cycle the word is
// taken; the result register then loads once any earlier result is taken. A
// put that runs off the bottom row scrolls, and a clear blanks the store; both
// walk the store once through its single write port. One word is in work at a
// time. The next word can be taken while a finished result still waits in the
// output register.
module text_console_writer_unit #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tcw_pkg::in_t                    in_data,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output tcw_pkg::out_t                   out_data,
  // colour registers
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]     cfg_wdata
);
  import tcw_pkg::*;

  localparam int CELL_CNT = SCREEN_COLUMNS * SCREEN_ROWS;

  logic [COLOR_W-1:0] fg_color_r;
  logic [COLOR_W-1:0] bg_color_r;
  dp_cmd_t            ctrl_cmd;
  dp_stat_t           ctrl_stat;

  // colour registers, used for put, clear and scroll-blank cells written from now on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r <= FG_RESET;
      bg_color_r <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FG_COLOR: fg_color_r <= cfg_wdata;
        REG_BG_COLOR: bg_color_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencing: reset fill, idle, clear, scroll, result hand-off
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ctrl_stat (ctrl_stat),
    .ctrl_cmd  (ctrl_cmd)
  );

  // cursor, screen store and result register
  tcw_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .fg_color  (fg_color_r),
    .bg_color  (bg_color_r),
    .ctrl_cmd  (ctrl_cmd),
    .ctrl_stat (ctrl_stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // the reported cursor always lies on the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.cursor_pos) < CELL_CNT))
    else $error("cursor position beyond the screen");

  // one word in work at a time
  a_one_word_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word taken while the previous one is in work");

  // no word is taken just as reset ends and the fill starts
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("word taken before the store fill finished");

endmodule
